// ----- rtl/int_to_decimal_ascii_defines.svh -----
// Assertion macros shared by the int_to_decimal_ascii RTL.
`ifndef INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication
`define ITDA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itda assertion failed");

// next-cycle implication
`define ITDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itda assertion failed");

`endif

// ----- rtl/itda_pkg.sv -----
// Types, constants and digit step function for the decimal text converter.
package itda_pkg;

  localparam int unsigned NUM_DIGITS = 10;
  localparam logic [3:0]  LAST_POS   = 4'd9;
  localparam logic [5:0]  ASCII_ZERO  = 6'h30;
  localparam logic [5:0]  ASCII_MINUS = 6'h2D;

  // index 0 is the most significant place (1e9)
  localparam logic [NUM_DIGITS-1:0][33:0] POW10 = {
    34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
    34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
  };

  typedef struct packed {
    logic                        neg;
    logic [31:0]                 mag;
    logic [NUM_DIGITS-1:0][3:0]  digs;
  } itda_item_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [31:0] rem;
  } itda_step_t;

  // one decimal place: compare against the nine multiples of the place weight
  function automatic itda_step_t itda_digit_step(logic [31:0] mag, int unsigned pos);
    logic [33:0] m;
    logic [33:0] prod;
    logic [33:0] sub;
    logic [3:0]  d;
    itda_step_t  res;
    m    = {2'b00, mag};
    prod = 34'd0;
    sub  = 34'd0;
    d    = 4'd0;
    for (int j = 1; j <= 9; j++) begin
      prod = prod + POW10[pos];
      if (m >= prod) begin
        d   = 4'(j);
        sub = prod;
      end
    end
    res.digit = d;
    res.rem   = 32'(m - sub);
    return res;
  endfunction

endpackage

// ----- rtl/int_to_decimal_ascii.sv -----
// Top level: signed 32-bit integer to decimal ASCII characters.
// A word passes the input register and the ten digit stages, then loads the serializer.
// Throughput: one character per cycle while out_ready_i is high; a value gives
// 1 to 11 characters, and the next value follows without a gap.
// The input register, ten digit stages and serializer hold up to 12 values.
// Reset clears all valid bits; no other state is kept between words.
module int_to_decimal_ascii (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         char_code_o,
  output logic               last_o
);

  logic                 f_valid, f_ready;
  itda_pkg::itda_item_t f_item;
  logic                 d_valid, d_ready;
  itda_pkg::itda_item_t d_item;

  itda_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .valid_o    (f_valid),
    .ready_i    (f_ready),
    .item_o     (f_item)
  );

  itda_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .item_i  (f_item),
    .valid_o (d_valid),
    .ready_i (d_ready),
    .item_o  (d_item)
  );

  itda_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (d_valid),
    .ready_o     (d_ready),
    .item_i      (d_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule

// ----- rtl/itda_front.sv -----
// Input stage: registers the sign and the 32-bit magnitude.
module itda_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  value_i,
  output logic                valid_o,
  input  logic                ready_i,
  output itda_pkg::itda_item_t item_o
);

  logic                 valid_q;
  itda_pkg::itda_item_t item_q, item_d;

  assign in_ready_o = !valid_q || ready_i;

  always_comb begin
    item_d      = '0;
    item_d.neg  = value_i[31];
    item_d.mag  = value_i[31] ? (~value_i) + 32'd1 : value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/itda_digits.sv -----
// Ten-stage digit pipeline: one decimal place resolved per stage.
`include "int_to_decimal_ascii_defines.svh"

module itda_digits (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  itda_pkg::itda_item_t item_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output itda_pkg::itda_item_t item_o
);

  localparam int unsigned N = itda_pkg::NUM_DIGITS;

  logic                 valid_q [N];
  itda_pkg::itda_item_t item_q  [N];
  logic                 rdy     [N+1];

  assign rdy[N] = ready_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    itda_pkg::itda_item_t src;
    itda_pkg::itda_item_t nxt;
    logic                 src_v;
    itda_pkg::itda_step_t st;

    if (k == 0) begin : g_first
      assign src   = item_i;
      assign src_v = valid_i;
    end else begin : g_rest
      assign src   = item_q[k-1];
      assign src_v = valid_q[k-1];
    end

    assign rdy[k] = !valid_q[k] || rdy[k+1];

    always_comb begin
      st           = itda_pkg::itda_digit_step(src.mag, k);
      nxt          = src;
      nxt.mag      = st.rem;
      nxt.digs[k]  = st.digit;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (src_v && rdy[k]) begin
        item_q[k] <= nxt;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = valid_q[N-1];
  assign item_o  = item_q[N-1];

  // after the last place only a remainder of zero is left
  `ITDA_ASSERT_IMPL(a_rem_zero, clk_i, rst_ni, valid_q[N-1], item_q[N-1].mag == 32'd0)
  // top place never exceeds 4 for a 32-bit magnitude
  `ITDA_ASSERT_IMPL(a_top_digit, clk_i, rst_ni, valid_q[0], item_q[0].digs[0] <= 4'd4)
  // a stalled last stage keeps its word
  `ITDA_ASSERT_NEXT(a_hold, clk_i, rst_ni, valid_q[N-1] && !ready_i, valid_q[N-1])

endmodule

// ----- rtl/itda_serial.sv -----
// Output serializer: sign, leading-zero skip, one character per output handshake.
`include "int_to_decimal_ascii_defines.svh"

module itda_serial (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  itda_pkg::itda_item_t item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [5:0]           char_code_o,
  output logic                 last_o
);

  logic                                  busy_q;
  logic                                  neg_q;
  logic [3:0]                            pos_q;
  logic [itda_pkg::NUM_DIGITS-1:0][3:0]  digs_q;
  logic [3:0]                            start;
  logic                                  found;
  logic                                  take;
  logic                                  is_last;
  logic                                  load;

  always_comb begin
    start = itda_pkg::LAST_POS;
    found = 1'b0;
    for (int k = 0; k < int'(itda_pkg::NUM_DIGITS); k++) begin
      if (!found && item_i.digs[k] != 4'd0) begin
        start = 4'(k);
        found = 1'b1;
      end
    end
  end

  assign is_last = !neg_q && (pos_q == itda_pkg::LAST_POS);
  assign take    = busy_q && out_ready_i;
  assign ready_o = !busy_q || (take && is_last);
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      neg_q  <= 1'b0;
      pos_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      neg_q  <= item_i.neg;
      pos_q  <= start;
    end else if (take) begin
      if (neg_q) begin
        neg_q <= 1'b0;
      end else begin
        pos_q <= pos_q + 4'd1;
      end
      if (is_last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      digs_q <= item_i.digs;
    end
  end

  assign out_valid_o = busy_q;
  assign last_o      = is_last;
  assign char_code_o = neg_q ? itda_pkg::ASCII_MINUS
                             : itda_pkg::ASCII_ZERO + {2'b00, digs_q[pos_q]};

  `ITDA_ASSERT_IMPL(a_pos_range, clk_i, rst_ni, busy_q, pos_q <= itda_pkg::LAST_POS)
  `ITDA_ASSERT_IMPL(a_digit_char, clk_i, rst_ni, busy_q && !neg_q,
                    char_code_o >= 6'h30 && char_code_o <= 6'h39)
  `ITDA_ASSERT_NEXT(a_no_drop, clk_i, rst_ni, take && !is_last, busy_q)
  `ITDA_ASSERT_NEXT(a_sign_load, clk_i, rst_ni, load && item_i.neg, neg_q && busy_q)

endmodule
